// ===== src/arc_length_step_table_macros.svh =====
// Assertion helpers for the step table
`ifndef ARC_LENGTH_STEP_TABLE_MACROS_SVH
`define ARC_LENGTH_STEP_TABLE_MACROS_SVH

// same-cycle implication
`define ALS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/als_pkg.sv =====
package als_pkg;

	localparam logic [1:0] STATUS_MOVED  = 2'd0;
	localparam logic [1:0] STATUS_AT_END = 2'd1;
	localparam logic [1:0] STATUS_BEYOND = 2'd2;

	typedef struct packed {
		logic               action;
		logic               restart;
		logic signed [31:0] coord;
		logic signed [31:0] shape_value;
		logic        [31:0] step_length;
	} req_t;

	typedef struct packed {
		logic signed [31:0] new_coord;
		logic        [1:0]  status;
	} res_t;

endpackage

// ===== src/arc_length_step_table.sv =====
// Channel   Signals              Handshake
// request   req (req_t)          taken on clk rise when start=1 and busy=0
// result    result (res_t), done done high for one cycle, always taken
//
// Load: entry zero is written from idle, others via two squares and a 32-step root.
// Step request: trivial answers come from idle or the end check; otherwise a binary
// search, a scan over entries and up to two multiply-divide passes follow.
// Busy is high while a request is worked on, up to its result strobe or load write; results cannot stall.
// Reset clears the entry count and previous point; table memories are not cleared.
`include "arc_length_step_table_macros.svh"

module arc_length_step_table
	import als_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [16:0] {
		S_IDLE    = 17'b00000000000000001,
		S_LD_MX   = 17'b00000000000000010,
		S_LD_MY   = 17'b00000000000000100,
		S_LD_SUM  = 17'b00000000000001000,
		S_LD_SQRT = 17'b00000000000010000,
		S_LD_WR   = 17'b00000000000100000,
		S_END     = 17'b00000000001000000,
		S_BS_RD   = 17'b00000000010000000,
		S_BS_CHK  = 17'b00000000100000000,
		S_SEG     = 17'b00000001000000000,
		S_MUL     = 17'b00000010000000000,
		S_DIV     = 17'b00000100000000000,
		S_BASE    = 17'b00001000000000000,
		S_SCAN    = 17'b00010000000000000,
		S_FIN_RD  = 17'b00100000000000000,
		S_FIN     = 17'b01000000000000000,
		S_RES     = 17'b10000000000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] coord_mem [TABLE_DEPTH];
	logic        [31:0] len_mem   [TABLE_DEPTH];
	logic signed [31:0] coord_a_q, coord_b_q;
	logic        [31:0] len_a_q, len_b_q;
	logic [AW-1:0] rd_a, rd_b, wr_addr;
	logic          wr_en;
	logic signed [31:0] wr_coord;
	logic        [31:0] wr_len;

	logic [CW-1:0] count_q, n_q, i_q, j_q, m_q;
	logic [31:0]   prev_abs_q, last_len_q, abs_q;
	logic signed [31:0] prev_sh_q;
	req_t          req_q;
	logic [31:0]   op_a_q, op_b_q, rem_q, lo_q, div_q, root_q, base_q;
	logic signed [31:0] c0_q;
	logic [63:0]   acc_q;
	logic [33:0]   srem_q;
	logic [4:0]    cnt_q;
	logic [32:0]   tgt_q;
	logic          neg_q, phase_q;

	// combinational helpers
	logic [31:0]   absc, dx30, dx28, dy;
	logic [32:0]   dx_round;
	logic signed [32:0] dsh;
	logic [CW-1:0] m_w, nm2, i_cl, k_w;
	logic [CW:0]   mij;
	logic          mp1_ok, bs_hit, found;
	logic signed [32:0] w_s, off_s, off_cl, cw_s;
	logic [32:0]   tg_m_l0, t33;
	logic [31:0]   dl_f, num_f, mag_f, tot;
	logic [32:0]   r33, rsub;
	logic          dge;
	logic [35:0]   rn, trial, sdiff;
	logic          sge;
	logic [64:0]   sum65;

	always_comb begin
		absc     = req.coord[31] ? 32'(-req.coord) : req.coord;
		dx30     = (absc >= prev_abs_q) ? absc - prev_abs_q : prev_abs_q - absc;
		dx_round = {1'b0, dx30} + 33'd2;
		dx28     = 32'(dx_round >> 2);
		dsh      = 33'(req.shape_value) - 33'(prev_sh_q);
		dy       = dsh[32] ? 32'(-dsh) : dsh[31:0];

		mij    = {1'b0, i_q} + {1'b0, j_q};
		m_w    = mij[CW:1];
		nm2    = n_q - CW'(2);
		i_cl   = (i_q > nm2) ? nm2 : i_q;
		mp1_ok = ({1'b0, m_q} + (CW+1)'(1)) < {1'b0, n_q};
		bs_hit = (coord_a_q <= req_q.coord) && mp1_ok && (coord_b_q > req_q.coord);
		found  = {1'b0, len_a_q} >= tgt_q;
		k_w    = (i_q == '0) ? '0 : i_q - CW'(1);

		w_s    = 33'(coord_b_q) - 33'(coord_a_q);
		off_s  = 33'(req_q.coord) - 33'(coord_a_q);
		off_cl = off_s[32] ? 33'sd0 : ((off_s > w_s) ? w_s : off_s);

		dl_f    = len_b_q - len_a_q;
		tg_m_l0 = tgt_q - {1'b0, len_a_q};
		num_f   = (tg_m_l0 > {1'b0, dl_f}) ? dl_f : tg_m_l0[31:0];
		cw_s    = 33'(coord_b_q) - 33'(coord_a_q);
		mag_f   = cw_s[32] ? 32'(-cw_s) : cw_s[31:0];

		r33  = {rem_q, lo_q[31]};
		rsub = r33 - {1'b0, div_q};
		dge  = r33 >= {1'b0, div_q};

		rn    = {srem_q, acc_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		sdiff = rn - trial;
		sge   = rn >= trial;

		sum65 = {1'b0, acc_q} + {1'b0, rem_q, lo_q};
		t33   = {1'b0, last_len_q} + {1'b0, root_q};
		tot   = t33[32] ? 32'hFFFF_FFFF : t33[31:0];
	end

	always_comb begin
		rd_a     = '0;
		rd_b     = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_coord = req.coord;
		wr_len   = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_a  = AW'(count_q - CW'(1));
				wr_en = start && !busy && !req.action && (req.restart || count_q == '0);
			end
			S_LD_WR: begin
				wr_en    = 1'b1;
				wr_addr  = count_q[AW-1:0];
				wr_coord = req_q.coord;
				wr_len   = tot;
			end
			S_BS_RD: begin
				if (i_q < j_q) begin
					rd_a = m_w[AW-1:0];
					rd_b = AW'(m_w + CW'(1));
				end else begin
					rd_a = i_cl[AW-1:0];
					rd_b = AW'(i_cl + CW'(1));
				end
			end
			S_BASE:   rd_a = i_q[AW-1:0];
			S_SCAN:   rd_a = AW'(i_q + CW'(1));
			S_FIN_RD: begin
				rd_a = i_q[AW-1:0];
				rd_b = AW'(i_q + CW'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coord_mem[wr_addr] <= wr_coord;
			len_mem[wr_addr]   <= wr_len;
		end
		coord_a_q <= coord_mem[rd_a];
		coord_b_q <= coord_mem[rd_b];
		len_a_q   <= len_mem[rd_a];
		len_b_q   <= len_mem[rd_b];
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			prev_abs_q <= '0;
			prev_sh_q  <= '0;
			last_len_q <= '0;
			done       <= 1'b0;
			result     <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (!req.action) begin
							if (req.restart || count_q == '0) begin
								count_q    <= CW'(1);
								last_len_q <= '0;
								prev_abs_q <= absc;
								prev_sh_q  <= req.shape_value;
							end else if (count_q < DEPTH_C) begin
								state_q <= S_LD_MX;
							end
						end else if (count_q < CW'(2)) begin
							done   <= 1'b1;
							result <= '{new_coord: req.coord, status: STATUS_AT_END};
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_LD_MX:  state_q <= S_LD_MY;
				S_LD_MY:  state_q <= S_LD_SUM;
				S_LD_SUM: state_q <= sum65[64] ? S_LD_WR : S_LD_SQRT;
				S_LD_SQRT: begin
					if (cnt_q == 5'd31) state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					count_q    <= count_q + CW'(1);
					last_len_q <= tot;
					prev_abs_q <= abs_q;
					prev_sh_q  <= req_q.shape_value;
					state_q    <= S_IDLE;
				end
				S_END: begin
					if (req_q.coord >= coord_a_q) begin
						done    <= 1'b1;
						result  <= '{new_coord: req_q.coord, status: STATUS_AT_END};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BS_RD;
					end
				end
				S_BS_RD:  state_q <= (i_q < j_q) ? S_BS_CHK : S_SEG;
				S_BS_CHK: state_q <= S_BS_RD;
				S_SEG:    state_q <= (w_s > 33'sd0) ? S_MUL : S_BASE;
				S_MUL:    state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == 5'd31) state_q <= phase_q ? S_RES : S_BASE;
				end
				S_BASE:   state_q <= S_SCAN;
				S_SCAN: begin
					if (i_q == n_q) begin
						done    <= 1'b1;
						result  <= '{new_coord: req_q.coord, status: STATUS_BEYOND};
						state_q <= S_IDLE;
					end else if (found) begin
						state_q <= S_FIN_RD;
					end
				end
				S_FIN_RD: state_q <= S_FIN;
				S_FIN: begin
					if (dl_f == '0 || tgt_q <= {1'b0, len_a_q}) begin
						done    <= 1'b1;
						result  <= '{new_coord: coord_a_q, status: STATUS_MOVED};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_RES: begin
					done    <= 1'b1;
					result  <= '{new_coord: neg_q ? c0_q - $signed(lo_q) : c0_q + $signed(lo_q),
						status: STATUS_MOVED};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q  <= req;
				abs_q  <= absc;
				op_a_q <= dx28;
				op_b_q <= dy;
				n_q    <= count_q;
				i_q    <= '0;
				j_q    <= count_q;
			end
			S_LD_MX: {rem_q, lo_q} <= 64'(op_a_q) * 64'(op_a_q);
			S_LD_MY: begin
				acc_q          <= {rem_q, lo_q};
				{rem_q, lo_q}  <= 64'(op_b_q) * 64'(op_b_q);
			end
			S_LD_SUM: begin
				acc_q  <= sum65[63:0];
				srem_q <= '0;
				root_q <= sum65[64] ? 32'hFFFF_FFFF : '0;
				cnt_q  <= '0;
			end
			S_LD_SQRT: begin
				srem_q <= sge ? sdiff[33:0] : rn[33:0];
				root_q <= {root_q[30:0], sge};
				acc_q  <= acc_q << 2;
				cnt_q  <= cnt_q + 5'd1;
			end
			S_BS_RD: begin
				m_q <= m_w;
				if (!(i_q < j_q)) i_q <= i_cl;
			end
			S_BS_CHK: begin
				priority if (bs_hit) begin
					i_q <= m_q;
					j_q <= m_q;
				end else if (coord_a_q < req_q.coord) begin
					i_q <= m_q + CW'(1);
				end else begin
					j_q <= m_q;
				end
			end
			S_SEG: begin
				base_q  <= len_a_q;
				op_a_q  <= off_cl[31:0];
				op_b_q  <= len_b_q - len_a_q;
				div_q   <= w_s[31:0];
				phase_q <= 1'b0;
				lo_q    <= '0;
			end
			S_MUL: begin
				{rem_q, lo_q} <= 64'(op_a_q) * 64'(op_b_q);
				cnt_q         <= '0;
			end
			S_DIV: begin
				rem_q <= dge ? rsub[31:0] : r33[31:0];
				lo_q  <= {lo_q[30:0], dge};
				cnt_q <= cnt_q + 5'd1;
			end
			S_BASE: tgt_q <= {1'b0, base_q} + {1'b0, lo_q} + {1'b0, req_q.step_length};
			S_SCAN: begin
				if (i_q != n_q) i_q <= found ? k_w : i_q + CW'(1);
			end
			S_FIN: begin
				op_a_q  <= num_f;
				op_b_q  <= mag_f;
				div_q   <= dl_f;
				neg_q   <= cw_s[32];
				c0_q    <= coord_a_q;
				phase_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	`ALS_ASSERT_NOW(a_done_idle, done, state_q == S_IDLE, "result strobe outside idle")
	`ALS_ASSERT_NOW(a_count_max, 1'b1, count_q <= DEPTH_C, "entry count beyond table")
	`ALS_ASSERT_NEXT(a_load_silent, start && !busy && !req.action, !done,
		"load request produced a result")
	`ALS_ASSERT_NOW(a_div_bound, state_q == S_DIV, rem_q < div_q,
		"division remainder not below divisor")

endmodule
